FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the rate converter top module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define LIRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rate converter assertion failed");
// condition must never be seen outside reset
`define LIRC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rate converter forbidden condition seen");
`else
`define LIRC_ASSERT(lbl, clk, rst_n, prop)
`define LIRC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: sv/lirc_pkg.sv
// ----------------------------------------------------------------------------
// lirc_pkg
// types, constants and helpers of the linear interpolation rate converter
// ----------------------------------------------------------------------------
package lirc_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned PHASE_W  = 25;
    localparam int unsigned RATE_W   = 25;
    localparam int unsigned ACCEL_W  = 18;
    localparam int unsigned CFG_W    = 25;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0]  RATE_MIN  = 25'd1024;
    localparam logic [RATE_W-1:0]  RATE_MAX  = 25'd16777216;
    localparam logic [RATE_W-1:0]  RATE_RST  = 25'd65536;
    localparam logic [PHASE_W-1:0] PHASE_MAX = 25'h1FFFFFF;
    localparam logic [PHASE_W-1:0] ONE_Q16   = 25'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ACCEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_OUT
    } t_state;

    // clamp a signed wide rate into the legal Q16 range
    function automatic logic [RATE_W-1:0] clamp_rate(input logic signed [RATE_W+1:0] r);
        logic [RATE_W-1:0] res;
        if (r < $signed({2'b00, RATE_MIN})) begin
            res = RATE_MIN;
        end else if (r > $signed({2'b00, RATE_MAX})) begin
            res = RATE_MAX;
        end else begin
            res = r[RATE_W-1:0];
        end
        return res;
    endfunction

    // step back by one input sample, floor at zero
    function automatic logic [PHASE_W-1:0] phase_drop(input logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] res;
        if (p >= ONE_Q16) begin
            res = p - ONE_Q16;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

FILE: sv/lirc_interp_unit.sv
// ----------------------------------------------------------------------------
// lirc_interp_unit
// shared interpolator: prev + ((curr - prev) * frac) >>> 16
// ----------------------------------------------------------------------------
module lirc_interp_unit (
    input  logic signed [lirc_pkg::SAMPLE_W-1:0] i_prev,
    input  logic signed [lirc_pkg::SAMPLE_W-1:0] i_curr,
    input  logic        [lirc_pkg::FRAC_W-1:0]   i_frac,
    output logic signed [lirc_pkg::SAMPLE_W-1:0] o_result
);

    logic signed [lirc_pkg::SAMPLE_W:0]                   diff;
    logic signed [lirc_pkg::SAMPLE_W+lirc_pkg::FRAC_W+1:0] prod;
    logic signed [lirc_pkg::SAMPLE_W+1:0]                  term;

    always_comb begin
        diff = {i_curr[lirc_pkg::SAMPLE_W-1], i_curr}
             - {i_prev[lirc_pkg::SAMPLE_W-1], i_prev};
        // 17 x 17 signed product, frac zero extended
        prod = diff * $signed({1'b0, i_frac});
        // floor division by 2^16; result lies between prev and curr
        term = prod[lirc_pkg::SAMPLE_W+lirc_pkg::FRAC_W+1:lirc_pkg::FRAC_W];
        o_result = i_prev + term[lirc_pkg::SAMPLE_W-1:0];
    end

endmodule

FILE: sv/linear_interp_rate_converter_top.sv
// ----------------------------------------------------------------------------
// linear_interp_rate_converter_top
// linear interpolation sample rate converter, mono or stereo, Q16 position
// ----------------------------------------------------------------------------
// an accepted input steps the sequencer through ST_MUL_L (left product), ST_MUL_R
// (right product) and ST_OUT (hand-off), where the result is presented until taken;
//   the input is not ready again until the run ends; an input causing no result stays idle
// the single interpolation multiplier is time-shared between channels
// reset: synchronous, active low; control registers to defaults, no stored sample
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_interp_rate_converter_top #(
    parameter int unsigned MAX_OUTPUTS_PER_INPUT = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [lirc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [lirc_pkg::CFG_W-1:0]             i_cfg_data,
    // input request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [lirc_pkg::SAMPLE_W-1:0]   i_sample_left,
    input  logic signed [lirc_pkg::SAMPLE_W-1:0]   i_sample_right,
    // result request channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [lirc_pkg::SAMPLE_W-1:0]   o_out_left,
    output logic signed [lirc_pkg::SAMPLE_W-1:0]   o_out_right,
    output logic                                   o_last_of_run
);

    // run counter, wide enough for the last index of a run
    localparam int unsigned CNT_W =
        (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);

    // control state
    lirc_pkg::t_state r_state, n_state;
    logic                          r_have_prev, n_have_prev;
    logic                          r_stereo, n_stereo;
    logic [lirc_pkg::RATE_W-1:0]   r_rate, n_rate;
    logic [lirc_pkg::PHASE_W-1:0]  r_phase, n_phase;
    logic signed [lirc_pkg::ACCEL_W-1:0] r_accel, n_accel;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic                          r_last, n_last;

    // sample payload
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_prev_l, n_prev_l;
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_prev_r, n_prev_r;
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_cur_l, n_cur_l;
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_cur_r, n_cur_r;
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_out_l, n_out_l;
    logic signed [lirc_pkg::SAMPLE_W-1:0] r_out_r, n_out_r;

    // shared interpolator operands
    logic signed [lirc_pkg::SAMPLE_W-1:0] mul_prev;
    logic signed [lirc_pkg::SAMPLE_W-1:0] mul_curr;
    logic signed [lirc_pkg::SAMPLE_W-1:0] mul_res;

    // position and rate update
    logic [lirc_pkg::PHASE_W:0]          phase_sum;
    logic [lirc_pkg::PHASE_W-1:0]        phase_next;
    logic signed [lirc_pkg::RATE_W+1:0]  rate_sum;

    logic in_acc;
    logic out_acc;

    assign o_in_ready  = (r_state == lirc_pkg::ST_IDLE);
    assign o_out_valid = (r_state == lirc_pkg::ST_OUT);
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_last_of_run = r_last;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    // left channel in the first product step, right channel in the second
    always_comb begin
        if (r_state == lirc_pkg::ST_MUL_R) begin
            mul_prev = r_prev_r;
            mul_curr = r_cur_r;
        end else begin
            mul_prev = r_prev_l;
            mul_curr = r_cur_l;
        end
    end

    lirc_interp_unit u_interp (
        .i_prev   (mul_prev),
        .i_curr   (mul_curr),
        .i_frac   (r_phase[lirc_pkg::FRAC_W-1:0]),
        .o_result (mul_res)
    );

    // saturating position step and clamped rate step
    always_comb begin
        phase_sum = {1'b0, r_phase} + {1'b0, r_rate};
        if (phase_sum[lirc_pkg::PHASE_W]) begin
            phase_next = lirc_pkg::PHASE_MAX;
        end else begin
            phase_next = phase_sum[lirc_pkg::PHASE_W-1:0];
        end
        rate_sum = $signed({2'b00, r_rate})
                 + {{(lirc_pkg::RATE_W+2-lirc_pkg::ACCEL_W){r_accel[lirc_pkg::ACCEL_W-1]}},
                    r_accel};
    end

    // sequencer: next state and register updates
    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_stereo    = r_stereo;
        n_rate      = r_rate;
        n_phase     = r_phase;
        n_accel     = r_accel;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;

        // the user must send register writes only while idle; the block itself does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                lirc_pkg::CFG_STEREO_MODE: n_stereo = i_cfg_data[0];
                lirc_pkg::CFG_START_RATE:
                    n_rate = lirc_pkg::clamp_rate({2'b00, i_cfg_data});
                lirc_pkg::CFG_RATE_ACCEL:
                    n_accel = i_cfg_data[lirc_pkg::ACCEL_W-1:0];
                lirc_pkg::CFG_START_PHASE:
                    n_phase = {{(lirc_pkg::PHASE_W-lirc_pkg::FRAC_W){1'b0}},
                               i_cfg_data[lirc_pkg::FRAC_W-1:0]};
                default: ;
            endcase
        end

        unique case (r_state)
            lirc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_cur_l = i_sample_left;
                    n_cur_r = i_sample_right;
                    if (!r_have_prev) begin
                        // first sample is only stored
                        n_prev_l    = i_sample_left;
                        n_prev_r    = i_sample_right;
                        n_have_prev = 1'b1;
                    end else if (r_phase[lirc_pkg::PHASE_W-1:lirc_pkg::FRAC_W] != '0) begin
                        // position already past this sample, no result
                        n_phase  = lirc_pkg::phase_drop(r_phase);
                        n_prev_l = i_sample_left;
                        n_prev_r = i_sample_right;
                    end else begin
                        n_cnt   = '0;
                        n_state = lirc_pkg::ST_MUL_L;
                    end
                end
            end
            lirc_pkg::ST_MUL_L: begin
                n_out_l = mul_res;
                n_state = lirc_pkg::ST_MUL_R;
            end
            lirc_pkg::ST_MUL_R: begin
                n_out_r = r_stereo ? mul_res : '0;
                n_phase = phase_next;
                n_rate  = lirc_pkg::clamp_rate(rate_sum);
                // run ends when the position leaves this interval or the cap is hit
                n_last  = (phase_next[lirc_pkg::PHASE_W-1:lirc_pkg::FRAC_W] != '0)
                        || (r_cnt == CNT_LAST);
                n_state = lirc_pkg::ST_OUT;
            end
            lirc_pkg::ST_OUT: begin
                if (out_acc) begin
                    if (r_last) begin
                        n_phase  = lirc_pkg::phase_drop(r_phase);
                        n_prev_l = r_cur_l;
                        n_prev_r = r_cur_r;
                        n_state  = lirc_pkg::ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = lirc_pkg::ST_MUL_L;
                    end
                end
            end
            default: n_state = lirc_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lirc_pkg::ST_IDLE;
            r_have_prev <= 1'b0;
            r_stereo    <= 1'b0;
            r_rate      <= lirc_pkg::RATE_RST;
            r_phase     <= '0;
            r_accel     <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_stereo    <= n_stereo;
            r_rate      <= n_rate;
            r_phase     <= n_phase;
            r_accel     <= n_accel;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_prev_l    <= n_prev_l;
            r_prev_r    <= n_prev_r;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cur_l <= n_cur_l;
        r_cur_r <= n_cur_r;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    // a run is only entered with the position inside the current interval
    `LIRC_ASSERT(a_run_in_interval, i_clk, i_rst_n,
        (r_state == lirc_pkg::ST_MUL_L) |->
            (r_phase[lirc_pkg::PHASE_W-1:lirc_pkg::FRAC_W] == '0))
    // rate stays within its clamp range
    `LIRC_ASSERT(a_rate_range, i_clk, i_rst_n,
        (r_rate >= lirc_pkg::RATE_MIN) && (r_rate <= lirc_pkg::RATE_MAX))
    // input side closed while a result is presented
    `LIRC_ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, o_in_ready && o_out_valid)
    // mono results carry a silent right channel
    `LIRC_ASSERT(a_mono_right_zero, i_clk, i_rst_n,
        (o_out_valid && !r_stereo) |-> (o_out_right == '0))
    // the result at the cap always closes the run
    `LIRC_ASSERT(a_cap_closes_run, i_clk, i_rst_n,
        (o_out_valid && (r_cnt == CNT_LAST)) |-> o_last_of_run)

endmodule
